@@ sv/aes_pkg.sv @@
`default_nettype none
package aes_pkg;

  localparam int unsigned Rounds = 10;
  localparam int unsigned KeyWords = 22;

  typedef enum logic [0:0] {
    REQ_ENCRYPT = 1'b0,
    REQ_DECRYPT = 1'b1
  } req_type_e;

  typedef enum logic [0:0] {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic        req_type;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } aes_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_INIT,
    ST_ROUND,
    ST_DONE
  } aes_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic       load;       // capture input block
    logic       decrypt;
    logic       exp_start;  // load key registers into expansion state
    logic       exp_step;   // write round key exp_idx, advance schedule
    logic [3:0] exp_idx;
    logic       rd_en;      // read round key rd_idx
    logic [3:0] rd_idx;
    logic       init;       // initial key addition
    logic       round;      // one cipher round
    logic       last;       // final round (no column mix)
    logic       out_load;   // move state to output register
  } aes_cmd_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

@@ sv/aes_ctrl.sv @@
`default_nettype none
module aes_ctrl
  import aes_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire logic     decrypt_i,
  output aes_cmd_t      cmd_o
);

  aes_state_e state_q, state_d;
  logic       expanded_q, expanded_d;
  logic       dec_q, dec_d;
  logic [3:0] cnt_q, cnt_d;
  logic       ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      expanded_q <= 1'b0;
      dec_q      <= 1'b0;
      cnt_q      <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      expanded_q <= expanded_d;
      dec_q      <= dec_d;
      cnt_q      <= cnt_d;
      ovalid_q   <= ovalid_d;
    end
  end

  logic take;

  always_comb begin
    state_d    = state_q;
    expanded_d = expanded_q;
    dec_d      = dec_q;
    cnt_d      = cnt_q;
    ovalid_d   = ovalid_q;
    cmd_o      = '0;
    cmd_o.decrypt = dec_q;
    in_stall_o = (state_q != ST_IDLE);
    take       = in_valid_i && (state_q == ST_IDLE);
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          cmd_o.load = 1'b1;
          dec_d = decrypt_i;
          cnt_d = '0;
          if (expanded_q) begin
            state_d = ST_INIT;
            cmd_o.rd_en = 1'b1;
            cmd_o.rd_idx = decrypt_i ? 4'(Rounds) : 4'd0;
          end else begin
            state_d = ST_EXPAND;
            cmd_o.exp_start = 1'b1;
          end
        end
      end
      ST_EXPAND: begin
        cmd_o.exp_step = 1'b1;
        cmd_o.exp_idx  = cnt_q;
        if (cnt_q == 4'(Rounds)) begin
          expanded_d = 1'b1;
          cnt_d = '0;
          state_d = ST_INIT;
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_idx = dec_q ? 4'(Rounds) : 4'd0;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        cnt_d = 4'd1;
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_idx = dec_q ? 4'(Rounds - 1) : 4'd1;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        cmd_o.last  = (cnt_q == 4'(Rounds));
        if (cnt_q == 4'(Rounds)) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 4'd1;
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_idx = dec_q ? 4'(Rounds) - cnt_q - 4'd1 : cnt_q + 4'd1;
        end
      end
      ST_DONE: begin
        if (!ovalid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          ovalid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_we_i) expanded_d = 1'b0;
  end

  assign out_valid_o = ovalid_q;

endmodule
`default_nettype wire

@@ sv/aes_dp.sv @@
`default_nettype none
module aes_dp
  import aes_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic     cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire aes_in_t  in_i,
  input  wire aes_cmd_t cmd_i,
  output aes_out_t      out_o
);

  logic [63:0]  key_hi_q, key_lo_q;
  logic [127:0] ek_q;
  logic [7:0]   rc_q;
  logic [127:0] st_q;
  logic [127:0] rk_q;
  logic [63:0]  mem_hi [KeyWords/2];
  logic [63:0]  mem_lo [KeyWords/2];
  aes_out_t     out_q;

  // key registers; reset value zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_KEY_HIGH) key_hi_q <= cfg_data_i;
      else key_lo_q <= cfg_data_i;
    end
  end

  // next round key
  logic [127:0] ek_n;
  logic [31:0]  w0, w1, w2, w3, tw;
  always_comb begin
    tw = {sbox(ek_q[23:16]) ^ rc_q, sbox(ek_q[15:8]), sbox(ek_q[7:0]), sbox(ek_q[31:24])};
    w0 = ek_q[127:96] ^ tw;
    w1 = ek_q[95:64] ^ w0;
    w2 = ek_q[63:32] ^ w1;
    w3 = ek_q[31:0] ^ w2;
    ek_n = {w0, w1, w2, w3};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_start) begin
      ek_q <= {key_hi_q, key_lo_q};
      rc_q <= 8'h01;
    end else if (cmd_i.exp_step) begin
      ek_q <= ek_n;
      rc_q <= xtime(rc_q);
    end
    if (cmd_i.exp_step) begin
      mem_hi[cmd_i.exp_idx] <= ek_q[127:64];
      mem_lo[cmd_i.exp_idx] <= ek_q[63:0];
    end
    // forward the round key being written this cycle
    if (cmd_i.rd_en) begin
      if (cmd_i.exp_step && cmd_i.exp_idx == cmd_i.rd_idx) rk_q <= ek_q;
      else rk_q <= {mem_hi[cmd_i.rd_idx], mem_lo[cmd_i.rd_idx]};
    end
  end

  // round function; byte i at bits 127-8i
  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p, x;
    p = '0;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p ^= x;
      x = xtime(x);
    end
    return p;
  endfunction

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [127:0] ss, ms, rnd;
  always_comb begin
    for (int i = 0; i < 16; i++) s[i] = st_q[127-8*i -: 8];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (cmd_i.decrypt) t[((c + r) % 4) * 4 + r] = inv_sbox(s[c * 4 + r]);
        else t[c * 4 + r] = sbox(s[((c + r) % 4) * 4 + r]);
      end
    end
    for (int i = 0; i < 16; i++) ss[127-8*i -: 8] = t[i];
    // decrypt: add key before inverse mix
    ms = cmd_i.decrypt ? (ss ^ rk_q) : ss;
    for (int i = 0; i < 16; i++) t[i] = ms[127-8*i -: 8];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (cmd_i.decrypt)
          m[c*4+r] = gm(t[c*4+(r%4)], 4'd14) ^ gm(t[c*4+((r+1)%4)], 4'd11) ^
                     gm(t[c*4+((r+2)%4)], 4'd13) ^ gm(t[c*4+((r+3)%4)], 4'd9);
        else
          m[c*4+r] = gm(t[c*4+(r%4)], 4'd2) ^ gm(t[c*4+((r+1)%4)], 4'd3) ^
                     t[c*4+((r+2)%4)] ^ t[c*4+((r+3)%4)];
      end
    end
    for (int i = 0; i < 16; i++) rnd[127-8*i -: 8] = m[i];
    if (cmd_i.last) rnd = ms;
    if (!cmd_i.decrypt) rnd = rnd ^ rk_q;
    else if (cmd_i.last) rnd = ms;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) st_q <= {in_i.block_high, in_i.block_low};
    else if (cmd_i.init) st_q <= st_q ^ rk_q;
    else if (cmd_i.round) st_q <= rnd;
    if (cmd_i.out_load) out_q <= {st_q[127:64], st_q[63:0]};
  end

  assign out_o = out_q;

endmodule
`default_nettype wire

@@ sv/aes128_block_cipher.sv @@
// Channel   Dir  Handshake             Payload
// in        in   in_valid_i/in_stall_o   aes_in_t  (req_type, block_high, block_low)
// out       out  out_valid_o/out_stall_i aes_out_t (result_high, result_low)
// cfg       in   cfg_we_i                cfg_idx_i, cfg_data_i (key_high, key_low)
//
// One transaction at a time: accept (ST_IDLE), initial key add (ST_INIT), 10 rounds
// (ST_ROUND), load to the output register (ST_DONE); one round unit does every round.
// After a key write the first block first passes through key expansion (ST_EXPAND).
// Reset clears control and zeroes the key registers; round keys are rebuilt before use.
// A waiting result does not block the next accept; only the ST_DONE load waits for it.
`default_nettype none
module aes128_block_cipher
  import aes_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic      cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire aes_in_t   in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output aes_out_t       out_data_o
);

  aes_cmd_t cmd;

  aes_ctrl u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .decrypt_i(in_data_i.req_type), .cmd_o(cmd)
  );

  aes_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_i(in_data_i), .cmd_i(cmd),
    .out_o(out_data_o)
  );

endmodule
`default_nettype wire

@@ sv/aes_checker.sv @@
`default_nettype none
module aes_checker
  import aes_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire aes_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted twice in a row");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result too early");

endmodule

bind aes128_block_cipher aes_checker u_aes_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);
`default_nettype wire
